/* sv/pmc_pkg.sv */
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int AccW     = 40;
  localparam int SymW     = 5;
  localparam int NumCheck = 8;
  localparam int IdxW     = 3;
  localparam int TopShift = 35;

  typedef logic [AccW-1:0] acc_t;
  typedef logic [SymW-1:0] sym_t;
  typedef logic [IdxW-1:0] idx_t;

  localparam acc_t AccReset    = 40'h00_0000_0001;
  localparam acc_t AccKeepMask = 40'h07_FFFF_FFFF;
  localparam idx_t LastIdx     = 3'd7;

  localparam acc_t GenWords [SymW] = '{
    40'h98_F2BC_8E61,
    40'h79_B76D_99E2,
    40'hF3_3E5F_B3C4,
    40'hAE_2EAB_E2A8,
    40'h1E_4F43_E470
  };

  // checksum handed from the absorb logic to the output stage
  typedef struct packed {
    logic load;
    acc_t sum;
  } pmc_load_t;

  // one polymod step: shift in a symbol, fold back the bits that drop out
  function automatic acc_t pmc_absorb(acc_t acc, sym_t sym);
    acc_t nxt;
    sym_t top;
    top = acc[AccW-1:TopShift];
    nxt = ((acc & AccKeepMask) << SymW) ^ acc_t'(sym);
    for (int b = 0; b < SymW; b++) begin
      if (top[b]) begin
        nxt = nxt ^ GenWords[b];
      end
    end
    return nxt;
  endfunction

  // eight zero symbols then the final xor with one (linear, flattens to xor trees)
  function automatic acc_t pmc_finish(acc_t acc);
    acc_t a;
    a = acc;
    for (int k = 0; k < NumCheck; k++) begin
      a = pmc_absorb(a, '0);
    end
    return a ^ AccReset;
  endfunction

endpackage

/* sv/pmc_out_stage.sv */
`timescale 1ns / 1ps

module pmc_out_stage
  import pmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pmc_load_t   ld,
  output logic        can_load,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  logic busy_r, busy_nxt;
  idx_t idx_r, idx_nxt;
  acc_t sum_r;
  acc_t shift_r;
  logic take;
  logic last;

  assign last     = (idx_r == LastIdx);
  assign take     = busy_r && out_tready;
  assign can_load = !busy_r || (out_tready && last);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (ld.load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (take) begin
      idx_nxt = idx_r + idx_t'(1);
      if (last) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      sum_r   <= ld.sum;
      shift_r <= ld.sum;
    end else if (take) begin
      shift_r <= {shift_r[AccW-SymW-1:0], {SymW{1'b0}}};
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {3'b000, sum_r, shift_r[AccW-1:AccW-SymW]};
  assign out_tlast  = last;

  a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    ld.load |-> (!busy_r || (out_tready && last)))
    else $error("checksum loaded while previous one still draining");

  a_idx_only_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> busy_r)
    else $error("symbol index advanced with output idle");

  a_stay_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (take && !last && !ld.load) |=> out_tvalid)
    else $error("checksum run ended before eighth symbol");

  a_sum_stable : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !ld.load) |=> (sum_r == $past(sum_r)))
    else $error("full checksum changed during a run");

  a_first_symbol : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && idx_r == '0) |-> (shift_r == sum_r))
    else $error("first symbol not aligned to full checksum");

endmodule

/* sv/polymod_checksum_40bit.sv */
`timescale 1ns / 1ps
// load: a final symbol's checksum enters the output stage registers as the symbol is accepted;
//   the first check symbol is offered in the next cycle, and the eight results follow as out_tready allows
// throughput: one symbol per cycle while in_tready is high, set by the single-step absorb into
//   the accumulator; a final symbol waits until the output stage is empty or its eighth
//   transaction is taken, so a new checksum is never loaded while the last one still drains
// reset (rst_n low, synchronous): accumulator back to 1, output stage empty

module polymod_checksum_40bit
  import pmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [0:0]  in_tuser,   // [0] is_final
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [4:0] check_symbol, [44:5] full_checksum, [47:45] zero
  output logic        out_tlast   // end_of_checksum
);

  // running polymod accumulator
  acc_t      acc_r, acc_nxt;
  acc_t      absorbed;
  logic      in_take;
  logic      can_load;
  pmc_load_t ld;

  // only the low five bits of a symbol take part
  assign absorbed = pmc_absorb(acc_r, in_tdata[SymW-1:0]);

  // non-final symbols never wait on the output side
  assign in_tready = !in_tuser[0] || can_load;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    acc_nxt = acc_r;
    if (in_take) begin
      // a finished message restarts the accumulator at one
      acc_nxt = in_tuser[0] ? AccReset : absorbed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= AccReset;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // pad with eight zero symbols and xor with one in the same cycle
  assign ld.load = in_take && in_tuser[0];
  assign ld.sum  = pmc_finish(absorbed);

  pmc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import pmc_pkg::*;

  // generator taps, one per bit that drops out of the top of the accumulator
  localparam acc_t PolyTaps [5] = '{
    40'h98_F2BC_8E61,
    40'h79_B76D_99E2,
    40'hF3_3E5F_B3C4,
    40'hAE_2EAB_E2A8,
    40'h1E_4F43_E470
  };
  localparam acc_t     SeedValue   = 40'h00_0000_0001;
  localparam int       ChecksLen   = 8;
  localparam int       TargetItems = 330;
  localparam int       CalmAfter   = 290;  // no idling on either side past this point
  localparam int       HoldAfter   = 60;   // results taken before the long receiver hold
  localparam int       HoldCycles  = 120;
  localparam int       DrainCycles = 16;
  localparam logic [7:0] SepSymbol = 8'h00;

  // one expected checksum transaction
  typedef struct {
    sym_t check_sym;
    acc_t full_sum;
    logic last_sym;
  } check_word_t;

  // tracks the running polymod and the checksum symbols still owed by the block
  class checksum_tracker;
    acc_t        running_sum;
    check_word_t owed_checks[$];
    int          errors;

    function new();
      running_sum = SeedValue;
      errors      = 0;
    endfunction

    // shift one symbol into the polymod, folding back the five bits that leave the top
    function acc_t fold_symbol(acc_t a, logic [7:0] sym);
      acc_t       nxt;
      logic [4:0] spill;
      int         b;
      spill = a[39:35];
      nxt   = {a[34:0], 5'b0} ^ {35'b0, sym[4:0]};
      for (b = 0; b < 5; b++) begin
        if (spill[b]) begin
          nxt = nxt ^ PolyTaps[b];
        end
      end
      return nxt;
    endfunction

    // called once per accepted input transaction
    function void note_symbol(logic [7:0] sym, logic fin);
      acc_t        a;
      acc_t        sum;
      check_word_t w;
      int          k;
      a = fold_symbol(running_sum, sym);
      if (!fin) begin
        running_sum = a;
        return;
      end
      for (k = 0; k < ChecksLen; k++) begin
        a = fold_symbol(a, 8'h00);
      end
      sum = a ^ SeedValue;
      for (k = 0; k < ChecksLen; k++) begin
        w.check_sym = sym_t'(sum >> (35 - 5 * k));
        w.full_sum  = sum;
        w.last_sym  = (k == ChecksLen - 1);
        owed_checks.push_back(w);
      end
      running_sum = SeedValue;
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // called once per accepted result transaction
    task check_result(logic [47:0] data, logic last);
      check_word_t w;
      if (owed_checks.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h last=%b", data, last));
        return;
      end
      w = owed_checks.pop_front();
      if (data[4:0] !== w.check_sym)
        flag_mismatch($sformatf("check_symbol %h, want %h", data[4:0], w.check_sym));
      if (data[44:5] !== w.full_sum)
        flag_mismatch($sformatf("full_checksum %h, want %h", data[44:5], w.full_sum));
      if (last !== w.last_sym)
        flag_mismatch($sformatf("end_of_checksum %b, want %b", last, w.last_sym));
      if (data[47:45] !== 3'b000)
        flag_mismatch($sformatf("pad bits %b not zero", data[47:45]));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] symbol
  logic [0:0]  in_tuser;   // [0] is_final
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [4:0] check_symbol, [44:5] full_checksum, [47:45] zero
  logic        out_tlast;  // end_of_checksum

  checksum_tracker sb = new();

  logic [48:0] taken_results[$];  // {tlast, tdata} captured at the edge, checked mid-cycle
  int          items_sent    = 0;
  int          results_taken = 0;
  bit          calm          = 1'b0;

  polymod_checksum_40bit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // offer one symbol, maybe after a short idle burst, and wait for the transaction
  task automatic send_symbol(input logic [7:0] sym, input logic fin);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));  // junk while idle
      in_tuser  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_symbol(sym, fin);
    items_sent++;
  endtask

  // stimulus
  initial begin
    int         n_pre;
    int         n_pay;
    int         i;
    logic [7:0] s;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // one-symbol messages back to back: zero, all ones, wide symbol with zero low bits
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'hE0, 1'b1);
    // prefix, separator, payload with extremes and a wide payload value
    send_symbol(8'h62, 1'b0);
    send_symbol(8'h63, 1'b0);
    send_symbol(8'h68, 1'b0);
    send_symbol(SepSymbol, 1'b0);
    send_symbol(8'h1F, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h3F, 1'b0);
    send_symbol(8'h10, 1'b0);
    send_symbol(8'h1F, 1'b1);
    // all ones run so the top bits spill every tap
    for (i = 0; i < 5; i++) begin
      send_symbol(8'hFF, 1'b0);
    end
    send_symbol(8'hAA, 1'b1);
    // new message right after a checksum
    send_symbol(8'h55, 1'b0);
    send_symbol(8'h80, 1'b1);

    while (items_sent < TargetItems) begin
      if (items_sent >= CalmAfter) calm = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        // well-formed message: prefix chars, separator, payload, final on last
        n_pre = $urandom_range(1, 8);
        n_pay = $urandom_range(1, 20);
        for (i = 0; i < n_pre; i++) begin
          if ($urandom_range(0, 9) == 0) s = 8'($urandom_range(0, 255));
          else s = 8'h61 + 8'($urandom_range(0, 25));
          send_symbol(s, 1'b0);
        end
        send_symbol(SepSymbol, 1'b0);
        for (i = 0; i < n_pay; i++) begin
          if ($urandom_range(0, 4) == 0) s = 8'($urandom_range(0, 255));
          else s = 8'($urandom_range(0, 31));
          send_symbol(s, i == n_pay - 1);
        end
      end else begin
        // noise: any symbols, final flag anywhere
        n_pay = $urandom_range(1, 12);
        for (i = 0; i < n_pay; i++) begin
          send_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
    end
    in_tvalid <= 1'b0;

    // drain everything still owed, then give the block time to misbehave
    while (sb.owed_checks.size() != 0 || taken_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.owed_checks.size() != 0) sb.flag_mismatch("checksum symbols never arrived");

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold to back the block up
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        taken_results.push_back({out_tlast, out_tdata});
        results_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_taken >= HoldAfter) begin
        // long hold: sender keeps offering, output stage fills and the next final symbol stalls
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare mid-cycle so the check never races the input side's bookkeeping
  always @(negedge clk) begin
    logic [48:0] w;
    if (taken_results.size() != 0) begin
      w = taken_results.pop_front();
      sb.check_result(w[47:0], w[48]);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
